[rtl/pld_pkg.sv]
// ----------------------------------------------------------------------------
// pld_pkg: shared types and codes of the positional list
// Transaction structs, operation and status codes, and the per-cycle
// control word that is broadcast along the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int LEN_W   = 5;
    localparam int CMP_W   = 9;   // wide enough for any fill count up to 256

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_PUSH     = 3'd2;
    localparam logic [2:0] OP_POP_TAIL = 3'd3;
    localparam logic [2:0] OP_POP_HEAD = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]                operation;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value_in;
    } pld_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [1:0]                status;
        logic [LEN_W-1:0]          length;
    } pld_resp_t;

    // Broadcast to every cell; each cell decides its own move from it.
    typedef struct packed {
        logic                      shift_up;    // cells above where take left neighbor
        logic                      shift_down;  // cells at or above where take right neighbor
        logic                      write;       // cell at where loads value
        logic [POS_W-1:0]          where;
        logic signed [VALUE_W-1:0] value;
    } pld_ctrl_t;

endpackage : pld_pkg

`default_nettype wire

[rtl/pld_cell.sv]
// ----------------------------------------------------------------------------
// pld_cell: one list slot
// Holds one value and each cycle holds, loads the new value, or takes the
// value of its lower or upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_cell #(
    parameter int IDX = 0
) (
    input  wire                           clk,
    input  wire pld_pkg::pld_ctrl_t       ctrl,
    input  wire logic signed [31:0]       left_in,
    input  wire logic signed [31:0]       right_in,
    output logic signed [31:0]            q
);
    import pld_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.shift_up && (MY_IDX > ctrl.where))
        begin
            val_next = left_in;
        end
        if (ctrl.shift_down && (MY_IDX >= ctrl.where))
        begin
            val_next = right_in;
        end
        if (ctrl.write && (MY_IDX == ctrl.where))
        begin
            val_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule : pld_cell

`default_nettype wire

[rtl/positional_list_deque.sv]
// ----------------------------------------------------------------------------
// positional_list_deque: ordered list with indexed insert and delete
// Result: the result of a transaction accepted in one cycle shows on
// response, with done high, in the cycle after it.
// Throughput: one transaction per cycle; busy never rises, since every
// cell of the row shifts in the same cycle. The receiver cannot stall.
// Reset: rst_n clears the fill count and the done strobe; cell contents
// are left as they are and only cells below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_deque #(
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire pld_pkg::pld_req_t   request,
    output logic                     done,
    output pld_pkg::pld_resp_t       response
);
    import pld_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);   // fill count width
    localparam int IW = $clog2(DEPTH);       // cell index width

    // Row of cells and the control word broadcast along it.
    logic signed [VALUE_W-1:0] cell_q [DEPTH];
    pld_ctrl_t                 ctrl;

    logic [FW-1:0]  fill_reg;
    logic [FW-1:0]  fill_next;
    logic           done_reg;
    pld_resp_t      resp_reg;
    pld_resp_t      resp_next;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic [FW-1:0]  fill_m1;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] fill_w;

    // Every cell of the row updates in the same cycle, so there is never a reason to stall.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (fill_reg == FW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign fill_m1  = fill_reg - FW'(1);
    assign pos_w    = CMP_W'(request.position);
    assign fill_w   = CMP_W'(fill_reg);

    // Decode the transaction into a broadcast control word, the new fill
    // count and the response.
    always_comb
    begin
        ctrl             = '0;
        ctrl.value       = request.value_in;
        fill_next        = fill_reg;
        resp_next        = '0;
        resp_next.status = ST_OK;

        if (accept)
        begin
            case (request.operation)
                OP_INSERT:
                begin
                    if (pos_w > fill_w)
                    begin
                        resp_next.status = ST_RANGE;
                    end
                    else if (is_full)
                    begin
                        resp_next.status = ST_FULL;
                    end
                    else
                    begin
                        // Open a gap at position and drop the new value in it.
                        ctrl.shift_up = 1'b1;
                        ctrl.write    = 1'b1;
                        ctrl.where    = request.position;
                        fill_next     = fill_reg + FW'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (pos_w >= fill_w)
                    begin
                        resp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        // Close the gap: everything from position moves down.
                        ctrl.shift_down = 1'b1;
                        ctrl.where      = request.position;
                        fill_next       = fill_m1;
                    end
                end
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        resp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.write = 1'b1;
                        ctrl.where = POS_W'(fill_reg);
                        fill_next  = fill_reg + FW'(1);
                    end
                end
                OP_POP_TAIL:
                begin
                    if (is_empty)
                    begin
                        resp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        // Tail cell keeps its data; only the count drops.
                        resp_next.value_out = cell_q[fill_m1[IW-1:0]];
                        fill_next           = fill_m1;
                    end
                end
                OP_POP_HEAD:
                begin
                    if (is_empty)
                    begin
                        resp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        resp_next.value_out = cell_q[0];
                        ctrl.shift_down     = 1'b1;
                        ctrl.where          = '0;
                        fill_next           = fill_m1;
                    end
                end
                default:
                begin
                    // Unknown operation: report ok and leave the list alone.
                    resp_next.status = ST_OK;
                end
            endcase
        end

        resp_next.length = LEN_W'(fill_next);
    end

    // Cell chain: cell i sees cell i-1 on its left and cell i+1 on its right.
    // Outer inputs are tied to own data: cell 0 never uses its left one, the last cell holds on a shift down.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_w;
        logic signed [VALUE_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cell_q[i];
        end
        else
        begin : g_inner_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_q[i];
        end
        else
        begin : g_inner_r
            assign right_w = cell_q[i+1];
        end

        pld_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .left_in  (left_w),
            .right_in (right_w),
            .q        (cell_q[i])
        );
    end

    // Control state: fill count and the one-cycle done strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    // Response payload: load on every accepted transaction, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            resp_reg <= resp_next;
        end
    end

    assign done     = done_reg;
    assign response = resp_reg;

endmodule : positional_list_deque

`default_nettype wire

[rtl/pld_checker.sv]
// ----------------------------------------------------------------------------
// pld_checker: port-level checks of the positional list
// Watches the command and result ports and flags strobe timing and
// response contents that the list can never produce.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_checker #(
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire                      busy,
    input  wire pld_pkg::pld_req_t   request,
    input  wire                      done,
    input  wire pld_pkg::pld_resp_t  response
);
    import pld_pkg::*;

    // Every accepted transaction answers on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transaction gave no done strobe");

    // No strobe without a transaction accepted in the cycle before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("done strobe without an accepted transaction");

    // Only a successful pop returns data.
    a_value_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status != ST_OK)) |-> (response.value_out == '0))
        else $error("nonzero value on an error response");

    // Full status only when the list really holds DEPTH values.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == ST_FULL)) |-> (response.length == LEN_W'(DEPTH)))
        else $error("full status with a length other than depth");

    // A nonzero value came from a request that was a pop.
    a_pop_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.value_out != '0)) |->
            (($past(request.operation) == OP_POP_TAIL) ||
             ($past(request.operation) == OP_POP_HEAD)))
        else $error("value returned for an operation that is not a pop");

endmodule : pld_checker

bind positional_list_deque pld_checker #(
    .DEPTH (DEPTH)
) u_pld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
);

`default_nettype wire
